// ===== src/ddo_pkg.sv =====
// Shared types and constants for the differential drive odometry core.
`default_nettype none
package ddo_pkg;

  localparam int CordicSteps = 16;
  localparam int StepBits    = 4;
  localparam int AdvBits     = 20;
  localparam int SumBits     = 21;   // wheel sum / difference
  localparam int CoefBits    = 34;   // CORDIC datapath and second multiply operand
  localparam int ProdBits    = SumBits + CoefBits;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 32;

  localparam logic signed [CoefBits-1:0] CordicGainInit = 34'sd652032874;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_ANGLE_GAIN      = 2'd0,
    REG_INITIAL_X       = 2'd1,
    REG_INITIAL_Y       = 2'd2,
    REG_INITIAL_HEADING = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_PREP,
    ST_CORDIC,
    ST_MUL_START,
    ST_MUL,
    ST_OUT
  } state_t;

  // arctan(2^-i) with full circle = 2^32
  function automatic logic [31:0] atan_entry(input logic [StepBits-1:0] i);
    logic [31:0] v;
    case (i)
      4'd0:    v = 32'd536870912;
      4'd1:    v = 32'd316933406;
      4'd2:    v = 32'd167458907;
      4'd3:    v = 32'd85004756;
      4'd4:    v = 32'd42667331;
      4'd5:    v = 32'd21354465;
      4'd6:    v = 32'd10679838;
      4'd7:    v = 32'd5340245;
      4'd8:    v = 32'd2670163;
      4'd9:    v = 32'd1335087;
      4'd10:   v = 32'd667544;
      4'd11:   v = 32'd333772;
      4'd12:   v = 32'd166886;
      4'd13:   v = 32'd83443;
      4'd14:   v = 32'd41722;
      default: v = 32'd20861;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/differential_drive_odometry_core.sv =====
// Top level: differential drive dead-reckoning odometry.
// Steps per item: gain multiply, prep, 16 CORDIC steps, position multiply, output.
// The serial multipliers and the single CORDIC stage keep one item in flight at a time;
// a new item is taken only in idle, once the previous result has been accepted.
// Reset: pose and gain clear to zero; writes to pose registers load the pose.
`default_nettype none
module differential_drive_odometry_core #(
  parameter int ANGLE_BITS    = 16,
  parameter int POSITION_BITS = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic signed [ddo_pkg::AdvBits-1:0]      right_advance,
  input  wire logic signed [ddo_pkg::AdvBits-1:0]      left_advance,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [POSITION_BITS-1:0]              pos_x,
  output logic signed [POSITION_BITS-1:0]              pos_y,
  output logic signed [ANGLE_BITS-1:0]                 heading,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [ddo_pkg::CfgIdxBits-1:0]          cfg_index,
  input  wire logic [ddo_pkg::CfgDataBits-1:0]         cfg_data
);

  localparam int SW = ddo_pkg::SumBits;
  localparam int KW = ddo_pkg::CoefBits;
  localparam int PW = ddo_pkg::ProdBits;

  ddo_pkg::state_t state, state_next;

  logic [31:0]              angle_gain;
  logic [POSITION_BITS-1:0] x_acc;
  logic [POSITION_BITS-1:0] y_acc;
  logic [ANGLE_BITS-1:0]    heading_acc;

  logic signed [SW-1:0] wsum;

  logic signed [KW-1:0] cx, cy, cz;
  logic [1:0]           quad;
  logic [ddo_pkg::StepBits-1:0] step;

  logic                 mul_load, mul_go;
  logic signed [SW-1:0] mul_a;
  logic signed [KW-1:0] mul_bx, mul_by;
  logic                 done_x, done_y;
  logic signed [PW-1:0] prod_x, prod_y;

  logic in_fire, out_fire, cfg_fire;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ddo_pkg::ST_IDLE:      if (in_fire) state_next = ddo_pkg::ST_GAIN;
      ddo_pkg::ST_GAIN:      if (done_x) state_next = ddo_pkg::ST_PREP;
      ddo_pkg::ST_PREP:      state_next = ddo_pkg::ST_CORDIC;
      ddo_pkg::ST_CORDIC:    if (step == 4'(ddo_pkg::CordicSteps - 1))
                               state_next = ddo_pkg::ST_MUL_START;
      ddo_pkg::ST_MUL_START: state_next = ddo_pkg::ST_MUL;
      ddo_pkg::ST_MUL:       if (done_x) state_next = ddo_pkg::ST_OUT;
      ddo_pkg::ST_OUT:       if (out_ready) state_next = ddo_pkg::ST_IDLE;
      default:               state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    mul_load = 1'b0;
    mul_go = 1'b0;
    case (state)
      ddo_pkg::ST_IDLE:      in_ready = 1'b1;
      ddo_pkg::ST_MUL_START: mul_go = 1'b1;
      ddo_pkg::ST_OUT:       out_valid = 1'b1;
      default: ;
    endcase
    if (in_fire) mul_load = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ddo_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // multiplier operands: gain phase uses wheel difference, position phase wheel sum
  always_comb begin
    mul_a  = wsum;
    mul_bx = cx;
    mul_by = cy;
    if (mul_load) begin
      mul_a  = SW'(right_advance) - SW'(left_advance);
      mul_bx = KW'({1'b0, angle_gain});
    end else begin
      case (quad)
        2'd0:    begin mul_bx = cx;  mul_by = cy;  end
        2'd1:    begin mul_bx = -cy; mul_by = cx;  end
        2'd2:    begin mul_bx = -cx; mul_by = -cy; end
        default: begin mul_bx = cy;  mul_by = -cx; end
      endcase
    end
  end

  ddo_smul u_mul_x (
    .clk(clk), .rst(rst), .start(mul_load || mul_go),
    .mplier_in(mul_a), .mcand_in(mul_bx), .done(done_x), .product(prod_x)
  );

  ddo_smul u_mul_y (
    .clk(clk), .rst(rst), .start(mul_go),
    .mplier_in(mul_a), .mcand_in(mul_by), .done(done_y), .product(prod_y)
  );

  // rounding of products
  logic signed [PW-1:0] gain_rnd;
  logic signed [PW-1:0] dx_full, dy_full;
  assign gain_rnd = prod_x + PW'(64'sd1 <<< 23);
  assign dx_full  = (prod_x + PW'(64'sd1 <<< 30)) >>> 31;
  assign dy_full  = (prod_y + PW'(64'sd1 <<< 30)) >>> 31;

  // quadrant fold of the heading
  logic [31:0] ang32, ang_bias, zfold;
  assign ang32    = {heading_acc, {(32 - ANGLE_BITS){1'b0}}};
  assign ang_bias = ang32 + 32'h2000_0000;
  assign zfold    = ang32 - {ang_bias[31:30], 30'b0};

  logic signed [KW-1:0] sx, sy, at;
  assign sx = cx >>> step;
  assign sy = cy >>> step;
  assign at = KW'(ddo_pkg::atan_entry(step));

  logic [23:0] head_ext;
  logic [47:0] xin_ext, yin_ext;
  assign head_ext = {{8{cfg_data[15]}}, cfg_data[15:0]};
  assign xin_ext  = {{16{cfg_data[31]}}, cfg_data};
  assign yin_ext  = xin_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_gain  <= '0;
      x_acc       <= '0;
      y_acc       <= '0;
      heading_acc <= '0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          ddo_pkg::REG_ANGLE_GAIN:      angle_gain  <= cfg_data;
          ddo_pkg::REG_INITIAL_X:       x_acc       <= xin_ext[POSITION_BITS-1:0];
          ddo_pkg::REG_INITIAL_Y:       y_acc       <= yin_ext[POSITION_BITS-1:0];
          ddo_pkg::REG_INITIAL_HEADING: heading_acc <= head_ext[ANGLE_BITS-1:0];
          default: ;
        endcase
      end
      if (state == ddo_pkg::ST_GAIN && done_x)
        heading_acc <= heading_acc + gain_rnd[24 + ANGLE_BITS - 1:24];
      if (state == ddo_pkg::ST_MUL && done_y) begin
        x_acc <= x_acc + dx_full[POSITION_BITS-1:0];
        y_acc <= y_acc + dy_full[POSITION_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) wsum <= SW'(right_advance) + SW'(left_advance);
    case (state)
      ddo_pkg::ST_PREP: begin
        cx   <= ddo_pkg::CordicGainInit;
        cy   <= '0;
        cz   <= KW'(signed'(zfold));
        quad <= ang_bias[31:30];
        step <= '0;
      end
      ddo_pkg::ST_CORDIC: begin
        if (!cz[KW-1]) begin
          cx <= cx - sy;
          cy <= cy + sx;
          cz <= cz - at;
        end else begin
          cx <= cx + sy;
          cy <= cy - sx;
          cz <= cz + at;
        end
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

  assign pos_x   = x_acc;
  assign pos_y   = y_acc;
  assign heading = heading_acc;

endmodule
`default_nettype wire

// ===== src/ddo_smul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, MSB weight negative.
`default_nettype none
module ddo_smul (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  input  wire logic signed [ddo_pkg::SumBits-1:0]      mplier_in,
  input  wire logic signed [ddo_pkg::CoefBits-1:0]     mcand_in,
  output logic                                         done,
  output logic signed [ddo_pkg::ProdBits-1:0]          product
);

  localparam int PW = ddo_pkg::ProdBits;
  localparam int AW = ddo_pkg::SumBits;
  localparam int CW = $clog2(AW + 1);

  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] mcand;
  logic [AW-1:0]        mplier;
  logic [CW-1:0]        count;
  logic                 busy;
  logic signed [PW-1:0] term;

  always_comb begin
    term = mplier[0] ? mcand : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CW'(AW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= PW'(mcand_in);
      mplier <= mplier_in;
    end else if (busy) begin
      // sign bit of the multiplier carries negative weight
      if (count == CW'(AW - 1)) acc <= acc - term;
      else                      acc <= acc + term;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign product = acc;

endmodule
`default_nettype wire

// ===== src/ddo_checker.sv =====
// Port-level checks for the odometry core, bound to the top level.
`default_nettype none
module ddo_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // one item in flight: never ready for input while a result is shown
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while result pending");

  // no result the cycle after an item is taken
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !out_valid)
    else $error("result too early");

  // after a result is taken the core is ready again
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_ready) |=> in_ready)
    else $error("not ready after result");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready)
);
`default_nettype wire

// ===== tb/sv/tb_differential_drive_odometry_core.sv =====
// Testbench for the differential drive odometry core: directed and random ticks vs a pose predictor.
`timescale 1ns / 1ps
module tb_differential_drive_odometry_core;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] h;
  } pose_t;

  typedef struct {
    logic [19:0] r;
    logic [19:0] l;
    bit          typed;
    pose_t       pose;
  } tick_row_t;

  localparam int WatchdogLimit = 20000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic signed [ddo_pkg::AdvBits-1:0] right_advance;
  logic signed [ddo_pkg::AdvBits-1:0] left_advance;
  logic        out_valid;
  logic        out_ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [ddo_pkg::CfgIdxBits-1:0]  cfg_index;
  logic [ddo_pkg::CfgDataBits-1:0] cfg_data;

  differential_drive_odometry_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .right_advance(right_advance), .left_advance(left_advance),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted pose and gain
  logic [31:0] gain_q;
  logic [31:0] x_q;
  logic [31:0] y_q;
  logic [15:0] head_q;
  pose_t       pose_q[$];
  int          errors;
  int          idle_cycles;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          tx_mode[4] = '{0, 57, 0, 17};
  int          rx_mode[4] = '{0, 0, 57, 17};

  longint arctan_q30 [16] = '{
    536870912, 316933406, 167458907, 85004756,
    42667331, 21354465, 10679838, 5340245,
    2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic apply_register(input logic [1:0] idx, input logic [31:0] val);
    case (ddo_pkg::reg_index_t'(idx))
      ddo_pkg::REG_ANGLE_GAIN:      gain_q = val;
      ddo_pkg::REG_INITIAL_X:       x_q = val;
      ddo_pkg::REG_INITIAL_Y:       y_q = val;
      ddo_pkg::REG_INITIAL_HEADING: head_q = val[15:0];
      default: ;
    endcase
  endtask

  // dead-reckoning step: heading first, then position along the new heading
  function automatic pose_t advance_pose(input logic [19:0] r, input logic [19:0] l);
    longint d, s, prod, dth, cx, cy, z, sx, sy, c, sn, dx, dy;
    logic [31:0] a, zu;
    logic [1:0]  q;
    pose_t       p;
    d = longint'($signed(r)) - longint'($signed(l));
    s = longint'($signed(r)) + longint'($signed(l));
    prod = d * longint'({32'b0, gain_q});
    dth = (prod + (64'sd1 <<< 23)) >>> 24;
    head_q = head_q + dth[15:0];
    a = {head_q, 16'b0};
    q = 2'((a + 32'h2000_0000) >> 30);
    zu = a - {q, 30'b0};
    z = longint'($signed(zu));
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < 16; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (z >= 0) begin
        cx = cx - sy; cy = cy + sx; z = z - arctan_q30[i];
      end else begin
        cx = cx + sy; cy = cy - sx; z = z + arctan_q30[i];
      end
    end
    case (q)
      2'd0: begin c = cx;  sn = cy;  end
      2'd1: begin c = -cy; sn = cx;  end
      2'd2: begin c = -cx; sn = -cy; end
      default: begin c = cy; sn = -cx; end
    endcase
    dx = (s * c + (64'sd1 <<< 30)) >>> 31;
    dy = (s * sn + (64'sd1 <<< 30)) >>> 31;
    x_q = x_q + dx[31:0];
    y_q = y_q + dy[31:0];
    p.x = x_q;
    p.y = y_q;
    p.h = head_q;
    return p;
  endfunction

  task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drives one tick item; leaves valid high, next call or caller lowers it
  task automatic send_tick(input logic [19:0] r, input logic [19:0] l,
                           input bit typed, input pose_t typed_pose);
    pose_t p;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    right_advance <= r;
    left_advance  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = advance_pose(r, l);
    if (typed) pose_q.push_back(typed_pose);
    else pose_q.push_back(p);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  function automatic logic [19:0] pick_advance();
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(4000) - 2000;
      1: v = ($urandom_range(1) != 0) ? 524287 - $urandom_range(3) : -524288 + $urandom_range(3);
      default: v = $urandom;
    endcase
    return v[19:0];
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        $display("%0t: result with nothing expected x=%h y=%h h=%h", $time, pos_x, pos_y,
                 heading);
        errors++;
      end else begin
        if (pos_x !== pose_q[0].x) begin
          $display("%0t: pos_x expected %h actual %h", $time, pose_q[0].x, pos_x);
          errors++;
        end
        if (pos_y !== pose_q[0].y) begin
          $display("%0t: pos_y expected %h actual %h", $time, pose_q[0].y, pos_y);
          errors++;
        end
        if (heading !== pose_q[0].h) begin
          $display("%0t: heading expected %h actual %h", $time, pose_q[0].h, heading);
          errors++;
        end
        void'(pose_q.pop_front());
      end
    end
  end

  // nothing moving on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  tick_row_t ticks[$];
  logic [31:0] gain_set[8] = '{32'd0, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0000_0001,
                               32'h8000_0000, 32'h0040_0000, 32'h0010_0000, 32'h0300_0000};

  initial begin
    pose_t zero_pose;
    pose_t none;
    zero_pose = '0;
    none = '0;
    errors = 0;
    idle_cycles = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    right_advance = '0;
    left_advance = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gain_q = '0; x_q = '0; y_q = '0; head_q = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero gain after reset: no motion from zero ticks, heading held
    ticks.push_back('{20'sd0, 20'sd0, 1'b1, zero_pose});
    ticks.push_back('{20'h7FFFF, 20'h7FFFF, 1'b0, none});
    ticks.push_back('{20'h80000, 20'h80000, 1'b0, none});
    ticks.push_back('{20'h7FFFF, 20'h80000, 1'b0, none});
    ticks.push_back('{20'h80000, 20'h7FFFF, 1'b0, none});
    ticks.push_back('{20'h7FFFF, 20'h00000, 1'b0, none});
    ticks.push_back('{20'h00000, 20'h80000, 1'b0, none});
    ticks.push_back('{20'h00001, 20'hFFFFF, 1'b0, none});
    ticks.push_back('{20'hFFFFF, 20'h00001, 1'b0, none});
    ticks.push_back('{20'h12345, 20'h0ABCD, 1'b0, none});
    ticks.push_back('{20'h55555, 20'hAAAAA, 1'b0, none});
    foreach (ticks[i]) send_tick(ticks[i].r, ticks[i].l, ticks[i].typed, ticks[i].pose);
    drain_results();

    // extremes of gain and pose, heading wrapping
    write_register(ddo_pkg::REG_ANGLE_GAIN, 32'hFFFF_FFFF);
    write_register(ddo_pkg::REG_INITIAL_X, 32'h7FFF_FFFF);
    write_register(ddo_pkg::REG_INITIAL_Y, 32'h8000_0000);
    write_register(ddo_pkg::REG_INITIAL_HEADING, 32'h0000_7FFF);
    foreach (ticks[i]) send_tick(ticks[i].r, ticks[i].l, 1'b0, none);
    drain_results();

    for (int ph = 0; ph < 8; ph++) begin
      tx_idle_pct = tx_mode[ph % 4];
      rx_stall_pct = rx_mode[ph % 4];
      write_register(ddo_pkg::REG_ANGLE_GAIN, (ph == 7) ? $urandom : gain_set[ph]);
      write_register(ddo_pkg::REG_INITIAL_X, (ph == 1) ? 32'h8000_0000 : $urandom);
      write_register(ddo_pkg::REG_INITIAL_Y, (ph == 1) ? 32'h7FFF_FFFF : $urandom);
      write_register(ddo_pkg::REG_INITIAL_HEADING, (ph == 2) ? 32'h0000_8000 : $urandom);
      for (int n = 0; n < 88; n++) send_tick(pick_advance(), pick_advance(), 1'b0, none);
      drain_results();
    end

    if (errors == 0 && pose_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
